// File: hw/rtl/ngp_pkg.sv
// ----------------------------------------------------------------------------
// NMEA GGA/GSV parser package
// Shared constants, record types and per-character update functions.
// ----------------------------------------------------------------------------
`default_nettype none

package ngp_pkg;

   localparam int LINE_CAPACITY_DEF = 256;
   localparam int FRAC_DIGITS_DEF   = 5;

   localparam int HI_W   = 10;   // degrees part, saturating
   localparam int LO_W   = 7;    // whole minutes
   localparam int FRAC_W = 24;   // minute fraction digits
   localparam int CNT_W  = 10;   // count accumulator, saturating at 1000
   localparam int FCC_W  = 5;    // characters within a field, saturating

   localparam logic [FCC_W-1:0] COORD_CHARS = FCC_W'(19);
   localparam logic [FCC_W-1:0] COUNT_CHARS = FCC_W'(7);

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_C     = 8'h43;
   localparam logic [7:0] CH_G     = 8'h47;
   localparam logic [7:0] CH_L     = 8'h4C;
   localparam logic [7:0] CH_M     = 8'h4D;
   localparam logic [7:0] CH_N     = 8'h4E;
   localparam logic [7:0] CH_P     = 8'h50;
   localparam logic [7:0] CH_R     = 8'h52;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_W     = 8'h57;

   localparam logic [7:0] FLD_LAT     = 8'd2;
   localparam logic [7:0] FLD_LAT_DIR = 8'd3;
   localparam logic [7:0] FLD_LON     = 8'd4;
   localparam logic [7:0] FLD_LON_DIR = 8'd5;
   localparam logic [7:0] FLD_QUALITY = 8'd6;
   localparam logic [7:0] FLD_USED    = 8'd7;
   localparam logic [7:0] FLD_IN_VIEW = 8'd3;

   localparam logic [31:0] MAG_CAP = 32'h7FFF_FFFF;

   typedef enum logic [2:0] {
      KIND_OTHER = 3'd0,
      KIND_GGA   = 3'd1,
      KIND_GSV   = 3'd2,
      KIND_RMC   = 3'd3,
      KIND_GLL   = 3'd4
   } line_kind_type;

   typedef enum logic [1:0] {
      CNT_LEAD   = 2'd0,
      CNT_DIGITS = 2'd1,
      CNT_DONE   = 2'd2
   } count_phase_type;

   typedef enum logic [1:0] {
      CRD_LEAD = 2'd0,
      CRD_INT  = 2'd1,
      CRD_FRAC = 2'd2,
      CRD_DONE = 2'd3
   } coord_phase_type;

   typedef struct packed {
      logic [CNT_W-1:0] value;
      count_phase_type  phase;
      logic             neg;
   } count_acc_type;

   typedef struct packed {
      logic [HI_W-1:0]   hi;
      logic [LO_W-1:0]   lo;
      logic [FRAC_W-1:0] fpart;
      logic [2:0]        fdigits;
      coord_phase_type   phase;
      logic              neg;
      logic              nonempty;
   } coord_acc_type;

   typedef struct packed {
      logic [5:0][7:0] hdr;
      logic [2:0]      hdr_len;
      logic [7:0]      field_num;
      logic [FCC_W-1:0] field_chars;
      logic            star;
      coord_acc_type   lat;
      coord_acc_type   lon;
      logic            lat_sw;
      logic            lon_sw;
      count_acc_type   cnt3;
      count_acc_type   cnt6;
      count_acc_type   cnt7;
   } line_state_type;

   typedef struct packed {
      logic [HI_W-1:0]   hi;
      logic [LO_W-1:0]   lo;
      logic [FRAC_W-1:0] fpart;
      logic [2:0]        fdigits;
      logic              negate;
   } coord_rec_type;

   typedef struct packed {
      line_kind_type kind;
      logic [7:0]    quality;
      logic [7:0]    used;
      logic [7:0]    in_view;
      logic          lat_ne;
      logic          lon_ne;
   } side_type;

   typedef struct packed {
      side_type      side;
      coord_rec_type lat;
      coord_rec_type lon;
   } line_rec_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
   endfunction

   function automatic logic [FRAC_W-1:0] pow10(logic [2:0] e);
      logic [FRAC_W-1:0] r;
      case (e)
         3'd0:    r = FRAC_W'(1);
         3'd1:    r = FRAC_W'(10);
         3'd2:    r = FRAC_W'(100);
         3'd3:    r = FRAC_W'(1000);
         3'd4:    r = FRAC_W'(10000);
         3'd5:    r = FRAC_W'(100000);
         3'd6:    r = FRAC_W'(1000000);
         default: r = FRAC_W'(10000000);
      endcase
      return r;
   endfunction

   function automatic count_acc_type count_feed(count_acc_type a, logic [7:0] c);
      count_acc_type r;
      logic [13:0]   v;
      logic          take;
      r    = a;
      take = 1'b1;
      v    = '0;
      if (a.phase == CNT_DONE) begin
         take = 1'b0;
      end else if (a.phase == CNT_LEAD) begin
         if (is_blank(c)) begin
            take = 1'b0;
         end else begin
            r.phase = CNT_DIGITS;
            if (c == CH_PLUS || c == CH_MINUS) begin
               r.neg = (c == CH_MINUS);
               take  = 1'b0;
            end
         end
      end
      if (take) begin
         if (is_digit(c)) begin
            v = 14'(a.value) * 14'd10 + 14'(c[3:0]);
            r.value = (v > 14'd1000) ? CNT_W'(1000) : v[CNT_W-1:0];
         end else begin
            r.phase = CNT_DONE;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] count_result(count_acc_type a);
      logic [7:0] r;
      if (a.neg) r = 8'd0;
      else if (a.value > CNT_W'(255)) r = 8'd255;
      else r = a.value[7:0];
      return r;
   endfunction

   // Integer digits are kept as degrees and the last two digits (minutes).
   function automatic coord_acc_type coord_feed(coord_acc_type a, logic [7:0] c,
                                                logic [2:0] fmax);
      coord_acc_type r;
      logic [9:0]    full;
      logic [3:0]    carry;
      logic [13:0]   hn;
      logic          go;
      r     = a;
      go    = 1'b1;
      full  = '0;
      carry = '0;
      hn    = '0;
      if (a.phase == CRD_DONE) begin
         go = 1'b0;
      end else if (a.phase == CRD_LEAD) begin
         if (is_blank(c)) begin
            go = 1'b0;
         end else begin
            r.phase = CRD_INT;
            if (c == CH_PLUS || c == CH_MINUS) begin
               r.neg = (c == CH_MINUS);
               go    = 1'b0;
            end
         end
      end
      if (go) begin
         if (r.phase == CRD_INT) begin
            if (is_digit(c)) begin
               full = 10'(a.lo) * 10'd10 + 10'(c[3:0]);
               for (int k = 1; k < 10; k++) begin
                  if (full >= 10'(k * 100)) carry = 4'(k);
               end
               r.lo = LO_W'(full - 10'(carry) * 10'd100);
               hn   = 14'(a.hi) * 14'd10 + 14'(carry);
               r.hi = (hn > 14'(2**HI_W - 1)) ? '1 : hn[HI_W-1:0];
            end else if (c == CH_DOT) begin
               r.phase = CRD_FRAC;
            end else begin
               r.phase = CRD_DONE;
            end
         end else begin
            if (is_digit(c)) begin
               if (a.fdigits < fmax) begin
                  r.fpart   = a.fpart * FRAC_W'(10) + FRAC_W'(c[3:0]);
                  r.fdigits = a.fdigits + 3'd1;
               end
            end else begin
               r.phase = CRD_DONE;
            end
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ngp_channels.sv
// ----------------------------------------------------------------------------
// NMEA parser channels
// Valid/ready channels for received bytes and for per-line results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ngp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         line_kind;
   logic               has_fix;
   logic [7:0]         gps_quality;
   logic [7:0]         sats_used;
   logic [7:0]         sats_in_view;
   logic signed [31:0] latitude;
   logic signed [31:0] longitude;
   modport source (output valid, output line_kind, output has_fix, output gps_quality,
                   output sats_used, output sats_in_view, output latitude,
                   output longitude, input ready);
   modport sink   (input valid, input line_kind, input has_fix, input gps_quality,
                   input sats_used, input sats_in_view, input latitude,
                   input longitude, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ngp_line_tracker.sv
// ----------------------------------------------------------------------------
// NMEA line tracker
// Registers each byte, updates the line state and emits a line record at LF.
// ----------------------------------------------------------------------------
`default_nettype none

module ngp_line_tracker import ngp_pkg::*; #(
   parameter int LINE_CAPACITY          = LINE_CAPACITY_DEF,
   parameter int MINUTE_FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   ngp_req_if.sink      req_if,
   input  logic         rec_take,
   output line_rec_type rec,
   output logic         rec_valid
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [2:0] FMAX = 3'(MINUTE_FRACTION_DIGITS);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic [LEN_W-1:0] line_len_ff, line_len_in;
   line_state_type ln_ff, ln_in;
   line_rec_type   rec_ff, rec_in;
   logic           rec_valid_ff, rec_valid_in;

   logic [7:0] c;
   logic       emit, rec_free, byte_go, in_ready;

   function automatic line_kind_type kind_of(logic [5:0][7:0] h, logic [2:0] len);
      line_kind_type k;
      k = KIND_OTHER;
      if (len == 3'd6 && h[0] == CH_DOLLAR && h[1] == CH_G &&
          (h[2] == CH_P || h[2] == CH_N)) begin
         if (h[3] == CH_G && h[4] == CH_G && h[5] == CH_A) k = KIND_GGA;
         else if (h[3] == CH_G && h[4] == CH_S && h[5] == CH_V) k = KIND_GSV;
         else if (h[3] == CH_R && h[4] == CH_M && h[5] == CH_C) k = KIND_RMC;
         else if (h[3] == CH_G && h[4] == CH_L && h[5] == CH_L) k = KIND_GLL;
      end
      return k;
   endfunction

   function automatic coord_rec_type coord_rec(coord_acc_type a, logic sw);
      coord_rec_type r;
      r.hi      = a.hi;
      r.lo      = a.lo;
      r.fpart   = a.fpart;
      r.fdigits = a.fdigits;
      r.negate  = a.neg ^ sw;
      return r;
   endfunction

   assign c        = in_byte_ff;
   assign emit     = (c == CH_LF) && (line_len_ff != '0);
   assign rec_free = !rec_valid_ff || rec_take;
   assign byte_go  = in_valid_ff && (!emit || rec_free);
   assign in_ready = !in_valid_ff || byte_go;

   assign req_if.ready = in_ready;
   assign rec          = rec_ff;
   assign rec_valid    = rec_valid_ff;

   assign in_valid_in  = in_ready ? req_if.valid : in_valid_ff;
   assign rec_valid_in = rec_free ? (in_valid_ff && emit) : rec_valid_ff;

   // line state update for the byte in the input register
   always_comb begin
      ln_in       = ln_ff;
      line_len_in = line_len_ff;
      if (byte_go) begin
         if (c == CH_LF) begin
            ln_in       = '0;
            line_len_in = '0;
         end else if (c == CH_CR) begin
            ln_in = ln_ff;
         end else if (line_len_ff < LEN_W'(LINE_CAPACITY - 1)) begin
            line_len_in = line_len_ff + LEN_W'(1);
            if (!ln_ff.star) begin
               if (c == CH_STAR || c == CH_NUL) begin
                  ln_in.star = 1'b1;
               end else begin
                  if (ln_ff.hdr_len < 3'd6) begin
                     ln_in.hdr[ln_ff.hdr_len] = c;
                     ln_in.hdr_len            = ln_ff.hdr_len + 3'd1;
                  end
                  if (c == CH_COMMA) begin
                     if (ln_ff.field_num != 8'hFF) ln_in.field_num = ln_ff.field_num + 8'd1;
                     ln_in.field_chars = '0;
                  end else begin
                     case (ln_ff.field_num)
                        FLD_LAT: begin
                           if (ln_ff.field_chars < COORD_CHARS) begin
                              ln_in.lat          = coord_feed(ln_ff.lat, c, FMAX);
                              ln_in.lat.nonempty = 1'b1;
                           end
                        end
                        FLD_LAT_DIR: begin
                           if (ln_ff.field_chars == '0) ln_in.lat_sw = (c == CH_S || c == CH_W);
                           if (ln_ff.field_chars < COUNT_CHARS)
                              ln_in.cnt3 = count_feed(ln_ff.cnt3, c);
                        end
                        FLD_LON: begin
                           if (ln_ff.field_chars < COORD_CHARS) begin
                              ln_in.lon          = coord_feed(ln_ff.lon, c, FMAX);
                              ln_in.lon.nonempty = 1'b1;
                           end
                        end
                        FLD_LON_DIR: begin
                           if (ln_ff.field_chars == '0) ln_in.lon_sw = (c == CH_S || c == CH_W);
                        end
                        FLD_QUALITY: begin
                           if (ln_ff.field_chars < COUNT_CHARS)
                              ln_in.cnt6 = count_feed(ln_ff.cnt6, c);
                        end
                        FLD_USED: begin
                           if (ln_ff.field_chars < COUNT_CHARS)
                              ln_in.cnt7 = count_feed(ln_ff.cnt7, c);
                        end
                        default: begin
                           ln_in.field_chars = ln_in.field_chars;
                        end
                     endcase
                     if (ln_ff.field_chars != '1)
                        ln_in.field_chars = ln_ff.field_chars + FCC_W'(1);
                  end
               end
            end
         end else begin
            // overflow: drop the byte and restart the line
            ln_in       = '0;
            line_len_in = '0;
         end
      end
   end

   always_comb begin
      rec_in.side.kind    = kind_of(ln_ff.hdr, ln_ff.hdr_len);
      rec_in.side.quality = (ln_ff.field_num >= FLD_QUALITY) ? count_result(ln_ff.cnt6) : 8'd0;
      rec_in.side.used    = (ln_ff.field_num >= FLD_USED) ? count_result(ln_ff.cnt7) : 8'd0;
      rec_in.side.in_view = (ln_ff.field_num >= FLD_IN_VIEW) ? count_result(ln_ff.cnt3) : 8'd0;
      rec_in.side.lat_ne  = ln_ff.lat.nonempty;
      rec_in.side.lon_ne  = ln_ff.lon.nonempty;
      rec_in.lat          = coord_rec(ln_ff.lat, ln_ff.lat_sw);
      rec_in.lon          = coord_rec(ln_ff.lon, ln_ff.lon_sw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rec_valid_ff <= 1'b0;
         line_len_ff  <= '0;
         ln_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rec_valid_ff <= rec_valid_in;
         line_len_ff  <= line_len_in;
         ln_ff        <= ln_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_if.valid) in_byte_ff <= req_if.rx_byte;
      if (byte_go && emit) rec_ff <= rec_in;
   end

endmodule

`default_nettype wire

// File: hw/rtl/ngp_coord_conv.sv
// ----------------------------------------------------------------------------
// NMEA coordinate converter
// Turns degrees, minutes and minute fraction into signed degrees * 1e7.
// ----------------------------------------------------------------------------
`default_nettype none

module ngp_coord_conv import ngp_pkg::*; #(
   parameter int MINUTE_FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic          clock,
   input  logic          advance,
   input  coord_rec_type rec_in,
   output logic [31:0]   value
);

   // minutes scaled to 1e-6 (or 1e-7) units, then divided by 6 (or 60)
   localparam int FM       = (MINUTE_FRACTION_DIGITS > 6) ? MINUTE_FRACTION_DIGITS : 6;
   localparam int DIVISOR  = (MINUTE_FRACTION_DIGITS > 6) ? 15 : 3;
   localparam int SHIFT    = (MINUTE_FRACTION_DIGITS > 6) ? 2 : 1;
   localparam int LO_SCALE = 10 ** FM;
   localparam longint unsigned RECIP = (64'd1 << 32) / DIVISOR;

   logic [47:0]     frac_prod;
   logic [29:0]     n_sum;
   logic [29:0]     x1_ff, x1_in;
   logic [HI_W-1:0] hi1_ff, hi2_ff;
   logic            neg1_ff, neg2_ff;
   logic [61:0]     q_prod;
   logic [29:0]     q2_ff, x2_ff;
   logic [29:0]     rem, q_fix;
   logic [32:0]     mag;
   logic [30:0]     mag_sat;
   logic [31:0]     mag32;

   assign frac_prod = 48'(rec_in.fpart) * 48'(pow10(3'(FM) - rec_in.fdigits));
   assign n_sum     = 30'(rec_in.lo) * 30'(LO_SCALE) + frac_prod[29:0];
   assign x1_in     = n_sum >> SHIFT;
   assign q_prod    = 62'(x1_ff) * 62'(RECIP[31:0]);

   // reciprocal estimate is at most one low
   assign rem     = x2_ff - q2_ff * 30'(DIVISOR);
   assign q_fix   = (rem >= 30'(DIVISOR)) ? q2_ff + 30'd1 : q2_ff;
   assign mag     = 33'(hi2_ff) * 33'd10000000 + 33'(q_fix);
   assign mag_sat = (hi2_ff > HI_W'(214) || mag > 33'(MAG_CAP)) ? MAG_CAP[30:0] : mag[30:0];
   assign mag32   = {1'b0, mag_sat};
   assign value   = neg2_ff ? (~mag32 + 32'd1) : mag32;

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff   <= x1_in;
         hi1_ff  <= rec_in.hi;
         neg1_ff <= rec_in.negate;
         q2_ff   <= q_prod[61:32];
         x2_ff   <= x1_ff;
         hi2_ff  <= hi1_ff;
         neg2_ff <= neg1_ff;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/nmea_gga_gsv_stream_parser.sv
// ----------------------------------------------------------------------------
// NMEA GGA/GSV stream parser
// Splits received text into lines and reports fix, satellite counts and position.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_if    in   valid/ready    rx_byte
//  rsp_if    out  valid/ready    line_kind, has_fix, gps_quality, sats_used,
//                                sats_in_view, latitude, longitude
//
//  One byte is taken every cycle unless an LF waits on a full line record stage.
//  A result passes the input register, line record, two conversion stages and
//  the output register. Synchronous reset clears the line state and all held
//  values to zero. A stalled result holds the record and conversion stages;
//  bytes keep flowing until an LF finds the line record stage still occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gga_gsv_stream_parser import ngp_pkg::*; #(
   parameter int LINE_CAPACITY          = LINE_CAPACITY_DEF,
   parameter int MINUTE_FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   ngp_req_if.sink    req_if,
   ngp_rsp_if.source  rsp_if
);

   line_rec_type rec;
   logic         rec_valid;
   logic         advance;
   logic [31:0]  lat_val, lon_val;

   logic     s1_valid_ff, s2_valid_ff, out_valid_ff;
   side_type s1_side_ff, s2_side_ff;

   logic [7:0]  held_quality_ff, held_quality_in;
   logic [7:0]  held_used_ff, held_used_in;
   logic [7:0]  held_view_ff, held_view_in;
   logic        held_fix_ff, held_fix_in;
   logic [31:0] held_lat_ff, held_lat_in;
   logic [31:0] held_lon_ff, held_lon_in;
   logic [2:0]  out_kind_ff;

   assign advance = !out_valid_ff || rsp_if.ready;

   ngp_line_tracker #(
      .LINE_CAPACITY          (LINE_CAPACITY),
      .MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rec_take  (advance),
      .rec       (rec),
      .rec_valid (rec_valid)
   );

   ngp_coord_conv #(.MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)) u_lat_conv (
      .clock   (clock),
      .advance (advance),
      .rec_in  (rec.lat),
      .value   (lat_val)
   );

   ngp_coord_conv #(.MINUTE_FRACTION_DIGITS (MINUTE_FRACTION_DIGITS)) u_lon_conv (
      .clock   (clock),
      .advance (advance),
      .rec_in  (rec.lon),
      .value   (lon_val)
   );

   // apply the finished line to the held values
   always_comb begin
      held_quality_in = held_quality_ff;
      held_used_in    = held_used_ff;
      held_view_in    = held_view_ff;
      held_fix_in     = held_fix_ff;
      held_lat_in     = held_lat_ff;
      held_lon_in     = held_lon_ff;
      if (s2_side_ff.kind == KIND_RMC) held_view_in = 8'd0;
      if (s2_side_ff.kind == KIND_GGA) begin
         held_quality_in = s2_side_ff.quality;
         held_used_in    = s2_side_ff.used;
         held_fix_in     = (s2_side_ff.quality != 8'd0) && s2_side_ff.lat_ne &&
                           s2_side_ff.lon_ne;
         if (held_fix_in) begin
            held_lat_in = lat_val;
            held_lon_in = lon_val;
         end
      end else if (s2_side_ff.kind == KIND_GSV) begin
         if (s2_side_ff.in_view > held_view_ff) held_view_in = s2_side_ff.in_view;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         held_quality_ff <= '0;
         held_used_ff    <= '0;
         held_view_ff    <= '0;
         held_fix_ff     <= 1'b0;
         held_lat_ff     <= '0;
         held_lon_ff     <= '0;
      end else if (advance) begin
         s1_valid_ff  <= rec_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
         if (s2_valid_ff) begin
            held_quality_ff <= held_quality_in;
            held_used_ff    <= held_used_in;
            held_view_ff    <= held_view_in;
            held_fix_ff     <= held_fix_in;
            held_lat_ff     <= held_lat_in;
            held_lon_ff     <= held_lon_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff  <= rec.side;
         s2_side_ff  <= s1_side_ff;
         out_kind_ff <= s2_side_ff.kind;
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.line_kind    = out_kind_ff;
   assign rsp_if.has_fix      = held_fix_ff;
   assign rsp_if.gps_quality  = held_quality_ff;
   assign rsp_if.sats_used    = held_used_ff;
   assign rsp_if.sats_in_view = held_view_ff;
   assign rsp_if.latitude     = held_lat_ff;
   assign rsp_if.longitude    = held_lon_ff;

`ifndef NO_ASSERTIONS
   a_fix_needs_quality : assert property (@(posedge clock) disable iff (reset)
      held_fix_ff |-> held_quality_ff != 8'd0)
      else $error("fix held with zero quality");

   a_rmc_clears_view : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_RMC) |-> held_view_ff == 8'd0)
      else $error("RMC result with satellites in view");

   a_gsv_never_lowers : assert property (@(posedge clock) disable iff (reset)
      (advance && s2_valid_ff && s2_side_ff.kind == KIND_GSV) |=>
      held_view_ff >= $past(held_view_ff))
      else $error("GSV line lowered satellites in view");
`endif

endmodule

`default_nettype wire
